[rtl/core/qtg_pkg.sv]
// Package for the greedy state-action value table.
// Holds table sizes, the command and result transfer types and the FSM state type.
// No dependencies.
`default_nettype none

package qtg_pkg;

    // Table geometry
    localparam int NUM_STATES  = 1024;
    localparam int MAX_ACTIONS = 16;
    localparam int STATE_W     = $clog2(NUM_STATES);
    localparam int ACTION_W    = $clog2(MAX_ACTIONS);
    localparam int ADDR_W      = STATE_W + ACTION_W;
    localparam int TABLE_DEPTH = NUM_STATES * MAX_ACTIONS;
    localparam int VALUE_W     = 32;
    localparam int CNT_W       = 5;

    // Operation codes
    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_READ   = 2'd1,
        MODE_GREEDY = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    // Input command transfer
    typedef struct packed {
        mode_t                     mode;
        logic [9:0]                state_index;
        logic [3:0]                action_index;
        logic signed [VALUE_W-1:0] write_value;
    } q_cmd_t;

    // Result transfer
    typedef struct packed {
        logic signed [VALUE_W-1:0] value_out;
        logic [3:0]                best_action;
        logic                      index_error;
    } q_result_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN
    } qtg_state_t;

endpackage

`default_nettype wire

[rtl/core/q_table_greedy_lookup.sv]
// Greedy state-action value table: top level with table memory and controller.
// Depends on qtg_pkg.
`default_nettype none

// The table holds 1024 states by 16 actions of signed Q16.16 words in one
// synchronous RAM. After reset the block sweeps the RAM to zero, one word per
// cycle, with busy high; configuration writes are still taken.
// A command is taken when start is high and busy is low. A write, an index
// error or the unused mode is finished from ST_IDLE and leaves busy low; a
// read goes through ST_READ, which loads the registered RAM word; a greedy
// query reads one action per cycle from the single RAM read port, over the
// effective action count (action_count, capped at 16). Each result shows on
// result with done high for exactly one cycle and must be taken then.
module q_table_greedy_lookup (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    start,
    output logic                   busy,
    input  qtg_pkg::q_cmd_t        cmd,
    output logic                   done,
    output qtg_pkg::q_result_t     result,
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire [4:0]              cfg_data
);
    import qtg_pkg::*;

    localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_ACTIONS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

    // Table memory
    logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic signed [VALUE_W-1:0] mem_wdata;
    logic                      mem_re;
    logic [ADDR_W-1:0]         mem_raddr;
    logic signed [VALUE_W-1:0] mem_rdata_reg;

    // Control and datapath registers
    qtg_state_t                state_reg, state_next;
    logic [ADDR_W-1:0]         clr_addr_reg, clr_addr_next;
    logic [STATE_W-1:0]        row_reg, row_next;
    logic [ACTION_W-1:0]       cmp_act_reg, cmp_act_next;
    logic signed [VALUE_W-1:0] best_value_reg, best_value_next;
    logic [ACTION_W-1:0]       best_act_reg, best_act_next;
    q_result_t                 result_reg, result_next;
    logic                      done_reg, done_next;
    logic [CNT_W-1:0]          action_count_reg;

    // Decoded command checks
    logic                      accept;
    logic [CNT_W-1:0]          eff_cnt;
    logic                      state_ok;
    logic                      action_ok;
    logic                      scan_last;
    logic                      take_new;

    assign accept    = start && (state_reg == ST_IDLE);
    assign eff_cnt   = (action_count_reg > MAX_CNT) ? MAX_CNT : action_count_reg;
    assign state_ok  = int'(cmd.state_index) < NUM_STATES;
    assign action_ok = CNT_W'(cmd.action_index) < eff_cnt;
    assign scan_last = (CNT_W'(cmp_act_reg) + CNT_W'(1)) >= eff_cnt;
    assign take_new  = (cmp_act_reg == '0) || (mem_rdata_reg > best_value_reg);

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && state_ok)
                begin
                    if (cmd.mode == MODE_READ && action_ok)
                    begin
                        state_next = ST_READ;
                    end
                    else if (cmd.mode == MODE_GREEDY && eff_cnt != '0)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory control, scan datapath and result
    always_comb
    begin
        mem_we          = 1'b0;
        mem_waddr       = {cmd.state_index, cmd.action_index};
        mem_wdata       = cmd.write_value;
        mem_re          = 1'b0;
        mem_raddr       = {cmd.state_index, cmd.action_index};
        clr_addr_next   = clr_addr_reg;
        row_next        = row_reg;
        cmp_act_next    = cmp_act_reg;
        best_value_next = best_value_reg;
        best_act_next   = best_act_reg;
        result_next     = result_reg;
        done_next       = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero one word per cycle
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    result_next = '0;
                    unique case (cmd.mode)
                        MODE_WRITE:
                        begin
                            if (state_ok && action_ok)
                            begin
                                mem_we = 1'b1;
                            end
                            else
                            begin
                                result_next.index_error = 1'b1;
                            end
                            done_next = 1'b1;
                        end
                        MODE_READ:
                        begin
                            if (state_ok && action_ok)
                            begin
                                mem_re = 1'b1;
                            end
                            else
                            begin
                                result_next.index_error = 1'b1;
                                done_next               = 1'b1;
                            end
                        end
                        MODE_GREEDY:
                        begin
                            if (state_ok && eff_cnt != '0)
                            begin
                                // Issue read of action zero
                                mem_re       = 1'b1;
                                mem_raddr    = {cmd.state_index, ACTION_W'(0)};
                                row_next     = cmd.state_index;
                                cmp_act_next = '0;
                            end
                            else
                            begin
                                result_next.index_error = 1'b1;
                                done_next               = 1'b1;
                            end
                        end
                        MODE_NONE:
                        begin
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                result_next           = '0;
                result_next.value_out = mem_rdata_reg;
                done_next             = 1'b1;
            end
            ST_SCAN:
            begin
                // Compare the arriving word, keep the first maximum
                if (take_new)
                begin
                    best_value_next = mem_rdata_reg;
                    best_act_next   = cmp_act_reg;
                end
                if (scan_last)
                begin
                    result_next             = '0;
                    result_next.value_out   = take_new ? mem_rdata_reg : best_value_reg;
                    result_next.best_action = 4'(take_new ? cmp_act_reg : best_act_reg);
                    done_next               = 1'b1;
                end
                else
                begin
                    // Advance to the next action
                    mem_re       = 1'b1;
                    mem_raddr    = {row_reg, cmp_act_reg + ACTION_W'(1)};
                    cmp_act_next = cmp_act_reg + ACTION_W'(1);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            done_reg         <= 1'b0;
            action_count_reg <= MAX_CNT;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                action_count_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        cmp_act_reg    <= cmp_act_next;
        best_value_reg <= best_value_next;
        best_act_reg   <= best_act_next;
        result_reg     <= result_next;
    end

endmodule

`default_nettype wire
